@@ sv/lz_window_byte_decompressor_macros.svh @@
// Assertion macros for the decompressor sequencer (lzwd_seq).
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef LZ_WINDOW_BYTE_DECOMPRESSOR_MACROS_SVH
`define LZ_WINDOW_BYTE_DECOMPRESSOR_MACROS_SVH

`define LZWD_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lzwd same-cycle check failed");

`define LZWD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lzwd next-cycle check failed");

`endif

@@ sv/lzwd_pkg.sv @@
package lzwd_pkg;

  localparam int unsigned WINDOW_DEPTH = 1024;
  localparam int unsigned MIN_COPY_LEN = 3;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CODE,
    PH_LITERAL,
    PH_DIST,
    PH_COPY
  } phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic       bad_distance;
  } out_t;

  typedef struct packed {
    logic valid;
    out_t item;
  } emit_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } win_ctrl_t;

endpackage

@@ sv/lzwd_stream_if.sv @@
interface lzwd_stream_if #(
  parameter type payload_t = logic [7:0]
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ sv/lzwd_window.sv @@
module lzwd_window #(
  parameter int unsigned WINDOW_DEPTH = lzwd_pkg::WINDOW_DEPTH,
  localparam int unsigned AW = $clog2(WINDOW_DEPTH)
) (
  input  logic               clk_i,
  input  lzwd_pkg::win_ctrl_t ctrl_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic [7:0]         wdata_i,
  input  logic [AW-1:0]      raddr_i,
  output logic [7:0]         rdata_o,
  output logic [7:0]         last_o
);

  logic [7:0] mem [WINDOW_DEPTH];
  logic [7:0] rdata_q;
  logic [7:0] last_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
      last_q       <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign last_o  = last_q;

endmodule

@@ sv/lzwd_seq.sv @@
`include "lz_window_byte_decompressor_macros.svh"

module lzwd_seq #(
  parameter int unsigned WINDOW_DEPTH = lzwd_pkg::WINDOW_DEPTH,
  localparam int unsigned AW = $clog2(WINDOW_DEPTH),
  localparam int unsigned DW = AW + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          in_byte_i,
  output logic                in_ready_o,
  input  logic                out_free_i,
  output lzwd_pkg::emit_t     emit_o,
  output lzwd_pkg::win_ctrl_t win_ctrl_o,
  output logic [AW-1:0]       waddr_o,
  output logic [7:0]          wdata_o,
  output logic [AW-1:0]       raddr_o,
  input  logic [7:0]          rdata_i,
  input  logic [7:0]          last_wr_i
);

  lzwd_pkg::phase_e ph_q, ph_d;
  logic [1:0]  hdr_q, hdr_d;
  logic [31:0] dest_q, dest_d;
  logic [32:0] written_q, written_d;
  logic [7:0]  lit_q, lit_d;
  logic [5:0]  len_q, len_d;
  logic [1:0]  hi_q, hi_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [DW-1:0] dist_q, dist_d;
  logic [AW-1:0] wp_q, wp_d;

  logic        acc;
  logic [32:0] written_inc;
  logic [31:0] dest_shift;
  logic [DW-1:0] dist_new;
  logic        reach;
  logic        bad;
  logic [7:0]  copy_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q      <= lzwd_pkg::PH_HEADER;
      hdr_q     <= '0;
      dest_q    <= '0;
      written_q <= '0;
      lit_q     <= '0;
      len_q     <= '0;
      hi_q      <= '0;
      cnt_q     <= '0;
      dist_q    <= '0;
      wp_q      <= '0;
    end else begin
      ph_q      <= ph_d;
      hdr_q     <= hdr_d;
      dest_q    <= dest_d;
      written_q <= written_d;
      lit_q     <= lit_d;
      len_q     <= len_d;
      hi_q      <= hi_d;
      cnt_q     <= cnt_d;
      dist_q    <= dist_d;
      wp_q      <= wp_d;
    end
  end

  always_comb begin
    in_ready_o  = (ph_q != lzwd_pkg::PH_COPY) &&
                  ((ph_q != lzwd_pkg::PH_LITERAL) || out_free_i);
    acc         = in_valid_i && in_ready_o;
    written_inc = written_q + 33'd1;
    reach       = written_inc >= {1'b0, dest_q};
    dest_shift  = {in_byte_i, dest_q[31:8]};
    dist_new    = DW'({hi_q, in_byte_i}) + DW'(1);
    bad         = written_q < 33'(dist_q);
    copy_byte   = bad ? 8'd0 : ((dist_q == DW'(1)) ? last_wr_i : rdata_i);

    ph_d      = ph_q;
    hdr_d     = hdr_q;
    dest_d    = dest_q;
    written_d = written_q;
    lit_d     = lit_q;
    len_d     = len_q;
    hi_d      = hi_q;
    cnt_d     = cnt_q;
    dist_d    = dist_q;
    wp_d      = wp_q;

    emit_o           = '0;
    win_ctrl_o       = '0;
    waddr_o          = wp_q;
    wdata_o          = in_byte_i;
    raddr_o          = wp_q - dist_new[AW-1:0];

    case (ph_q)
      lzwd_pkg::PH_HEADER: begin
        if (acc) begin
          dest_d = dest_shift;
          hdr_d  = hdr_q + 2'd1;
          if (hdr_q == 2'd3) begin
            written_d = '0;
            ph_d = (dest_shift == 32'd0) ? lzwd_pkg::PH_HEADER : lzwd_pkg::PH_CODE;
          end
        end
      end
      lzwd_pkg::PH_CODE: begin
        if (acc) begin
          if (in_byte_i[7]) begin
            len_d = 6'(in_byte_i[6:2]) + 6'(lzwd_pkg::MIN_COPY_LEN);
            hi_d  = in_byte_i[1:0];
            ph_d  = lzwd_pkg::PH_DIST;
          end else begin
            lit_d = 8'(in_byte_i[6:0]) + 8'd1;
            ph_d  = lzwd_pkg::PH_LITERAL;
          end
        end
      end
      lzwd_pkg::PH_LITERAL: begin
        if (acc) begin
          emit_o.valid             = 1'b1;
          emit_o.item.out_byte     = in_byte_i;
          emit_o.item.last_byte    = written_inc == {1'b0, dest_q};
          emit_o.item.bad_distance = 1'b0;
          win_ctrl_o.wr_en         = 1'b1;
          wp_d      = wp_q + AW'(1);
          written_d = written_inc;
          lit_d     = lit_q - 8'd1;
          if (lit_q == 8'd1) begin
            ph_d  = reach ? lzwd_pkg::PH_HEADER : lzwd_pkg::PH_CODE;
            hdr_d = '0;
          end
        end
      end
      lzwd_pkg::PH_DIST: begin
        if (acc) begin
          win_ctrl_o.rd_en = 1'b1;
          dist_d = dist_new;
          cnt_d  = len_q;
          len_d  = '0;
          hi_d   = '0;
          ph_d   = lzwd_pkg::PH_COPY;
        end
      end
      lzwd_pkg::PH_COPY: begin
        raddr_o = wp_q + AW'(1) - dist_q[AW-1:0];
        wdata_o = copy_byte;
        if (out_free_i) begin
          emit_o.valid             = 1'b1;
          emit_o.item.out_byte     = copy_byte;
          emit_o.item.last_byte    = written_inc == {1'b0, dest_q};
          emit_o.item.bad_distance = bad;
          win_ctrl_o.wr_en         = 1'b1;
          win_ctrl_o.rd_en         = 1'b1;
          wp_d      = wp_q + AW'(1);
          written_d = written_inc;
          cnt_d     = cnt_q - 6'd1;
          if (cnt_q == 6'd1) begin
            ph_d  = reach ? lzwd_pkg::PH_HEADER : lzwd_pkg::PH_CODE;
            hdr_d = '0;
          end
        end
      end
      default: begin
        ph_d = lzwd_pkg::PH_HEADER;
      end
    endcase
  end

  `LZWD_ASSERT_IMP(a_copy_blocks_input, ph_q == lzwd_pkg::PH_COPY, !in_ready_o)
  `LZWD_ASSERT_IMP(a_emit_needs_room, emit_o.valid, out_free_i)
  `LZWD_ASSERT_IMP(a_bad_only_zero_copy, emit_o.valid && emit_o.item.bad_distance,
                   ph_q == lzwd_pkg::PH_COPY && emit_o.item.out_byte == 8'd0)
  `LZWD_ASSERT_NEXT(a_copy_ends, ph_q == lzwd_pkg::PH_COPY && out_free_i && cnt_q == 6'd1,
                    ph_q != lzwd_pkg::PH_COPY)
  `LZWD_ASSERT_NEXT(a_dist_starts_copy, ph_q == lzwd_pkg::PH_DIST && acc,
                    ph_q == lzwd_pkg::PH_COPY && cnt_q >= 6'(lzwd_pkg::MIN_COPY_LEN))

endmodule

@@ sv/lz_window_byte_decompressor.sv @@
// Byte-stream LZ decompressor with a history window.
// The in_i channel takes one compressed byte per item: four little-endian
// length bytes, then tokens. A literal token is a code byte followed by its
// literal bytes; a copy token is a code byte followed by one distance byte.
// The out_o channel gives one decompressed byte per item, with last_byte on
// the byte that reaches the stream length and bad_distance on copied bytes
// that lay before the stream start (those read as zero).
// Header, code and distance bytes give no output.
// A literal byte goes into the output register and appears on out_o in the
// cycle after it is accepted. After a distance byte the copy runs at one byte
// per cycle while out_o takes bytes; in_i is not ready meanwhile.
// A copy of L bytes thus holds the input until all L bytes are emitted.
// A stall on out_o holds the output register and freezes a running copy;
// literal bytes are refused while the output register stays full.
// Reset returns the block to expecting a header. The window takes no
// clearing pass, since a copy only reads slots written since reset.
module lz_window_byte_decompressor #(
  parameter int unsigned WINDOW_DEPTH = lzwd_pkg::WINDOW_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  lzwd_stream_if.sink    in_i,
  lzwd_stream_if.source  out_o
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);

  lzwd_pkg::emit_t     emit;
  lzwd_pkg::win_ctrl_t win_ctrl;
  lzwd_pkg::in_t       in_item;
  lzwd_pkg::out_t      out_q;
  logic                out_valid_q;
  logic                out_free;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;
  logic [7:0]          wdata;
  logic [7:0]          rdata;
  logic [7:0]          last_wr;

  assign in_item  = in_i.payload;
  assign out_free = !out_valid_q || out_o.ready;

  lzwd_seq #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_byte_i  (in_item.in_byte),
    .in_ready_o (in_i.ready),
    .out_free_i (out_free),
    .emit_o     (emit),
    .win_ctrl_o (win_ctrl),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .raddr_o    (raddr),
    .rdata_i    (rdata),
    .last_wr_i  (last_wr)
  );

  lzwd_window #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .ctrl_i  (win_ctrl),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata),
    .last_o  (last_wr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_q <= emit.item;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

@@ tb/sv/lzwd_stream_checker.sv @@
module lzwd_stream_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  lzwd_pkg::in_t  in_item_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  lzwd_pkg::out_t out_item_i,
  output int unsigned    errors_o,
  output int unsigned    pending_o,
  output int unsigned    checked_o,
  output int unsigned    flagged_o,
  output int unsigned    stream_ends_o,
  output logic           stream_idle_o
);
  timeunit 1ns;
  timeprecision 1ps;

  lzwd_pkg::phase_e phase;
  logic [1:0]  hdr_cnt;
  logic [31:0] stream_len;
  logic [32:0] produced;
  logic [7:0]  lit_left;
  logic [5:0]  copy_len;
  logic [1:0]  dist_hi;
  logic [7:0]  history [lzwd_pkg::WINDOW_DEPTH];
  logic [9:0]  wr_ptr;

  lzwd_pkg::out_t expected_bytes_q [$];
  int unsigned mismatches;
  int unsigned checked;
  int unsigned flagged;
  int unsigned stream_ends;

  function automatic void emit_byte(input logic [7:0] value, input logic bad);
    lzwd_pkg::out_t r;
    history[wr_ptr] = value;
    wr_ptr = wr_ptr + 1'b1;
    produced = produced + 1'b1;
    r.out_byte = value;
    r.last_byte = (produced == {1'b0, stream_len});
    r.bad_distance = bad;
    expected_bytes_q.push_back(r);
  endfunction

  function automatic void close_token();
    if (produced >= {1'b0, stream_len}) begin
      phase = lzwd_pkg::PH_HEADER;
      hdr_cnt = '0;
    end else begin
      phase = lzwd_pkg::PH_CODE;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    logic [10:0] distance;
    logic [9:0]  src;
    case (phase)
      lzwd_pkg::PH_HEADER: begin
        if (hdr_cnt == 2'd0) stream_len = '0;
        stream_len[hdr_cnt*8 +: 8] = b;
        hdr_cnt = hdr_cnt + 1'b1;
        if (hdr_cnt == 2'd0) begin
          produced = '0;
          phase = (stream_len == 32'd0) ? lzwd_pkg::PH_HEADER : lzwd_pkg::PH_CODE;
        end
      end
      lzwd_pkg::PH_CODE: begin
        if (b[7]) begin
          copy_len = {1'b0, b[6:2]} + 6'(lzwd_pkg::MIN_COPY_LEN);
          dist_hi = b[1:0];
          phase = lzwd_pkg::PH_DIST;
        end else begin
          lit_left = {1'b0, b[6:0]} + 8'd1;
          phase = lzwd_pkg::PH_LITERAL;
        end
      end
      lzwd_pkg::PH_LITERAL: begin
        emit_byte(b, 1'b0);
        lit_left = lit_left - 8'd1;
        if (lit_left == 8'd0) close_token();
      end
      lzwd_pkg::PH_DIST: begin
        distance = {1'b0, dist_hi, b} + 11'd1;
        for (int i = 0; i < copy_len; i++) begin
          if (produced < {22'd0, distance}) begin
            emit_byte(8'd0, 1'b1);
          end else begin
            src = wr_ptr - distance[9:0];
            emit_byte(history[src], 1'b0);
          end
        end
        copy_len = '0;
        dist_hi = '0;
        close_token();
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lzwd_pkg::out_t want;
    if (!rst_ni) begin
      phase = lzwd_pkg::PH_HEADER;
      hdr_cnt = '0;
      stream_len = '0;
      produced = '0;
      lit_left = '0;
      copy_len = '0;
      dist_hi = '0;
      wr_ptr = '0;
      foreach (history[k]) history[k] = '0;
      expected_bytes_q.delete();
      mismatches = 0;
      checked = 0;
      flagged = 0;
      stream_ends = 0;
    end else begin
      if (in_valid_i && in_ready_i) decode_byte(in_item_i.in_byte);
      if (out_valid_i && out_ready_i) begin
        if (expected_bytes_q.size() == 0) begin
          $error("out_byte %02h arrived with no byte expected", out_item_i.out_byte);
          mismatches++;
        end else begin
          want = expected_bytes_q.pop_front();
          checked++;
          if (out_item_i.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_item_i.out_byte);
            mismatches++;
          end
          if (out_item_i.last_byte !== want.last_byte) begin
            $error("last_byte: expected %0b, got %0b", want.last_byte, out_item_i.last_byte);
            mismatches++;
          end
          if (out_item_i.bad_distance !== want.bad_distance) begin
            $error("bad_distance: expected %0b, got %0b", want.bad_distance,
                   out_item_i.bad_distance);
            mismatches++;
          end
          if (want.bad_distance) flagged++;
          if (want.last_byte) stream_ends++;
        end
      end
    end
    errors_o      <= mismatches;
    pending_o     <= expected_bytes_q.size();
    checked_o     <= checked;
    flagged_o     <= flagged;
    stream_ends_o <= stream_ends;
    stream_idle_o <= (phase == lzwd_pkg::PH_HEADER) && (hdr_cnt == 2'd0);
  end

endmodule

@@ tb/sv/lz_window_byte_decompressor_tb.sv @@
module lz_window_byte_decompressor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] byte_q_t [$];

  localparam int unsigned TOTAL_ITEMS  = 420;
  localparam int unsigned HOLD_AT      = 150;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned QUIET_FROM   = 220;
  localparam int unsigned QUIET_TO     = 300;
  localparam int unsigned DRAIN_AT     = 330;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned FINAL_TOKENS = 6;
  localparam int unsigned ANY_TOKENS   = 32'hFFFF_FFFF;
  localparam logic [7:0]  COPY_FLAG    = 8'h80;
  localparam logic [7:0]  LONG_COPY    = 8'hFC;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int unsigned sent_items = 0;
  int unsigned pending;
  int unsigned mismatches;
  int unsigned checked;
  int unsigned flagged;
  int unsigned stream_ends;
  logic        stream_idle;

  lzwd_stream_if #(.payload_t(lzwd_pkg::in_t))  in_ch ();
  lzwd_stream_if #(.payload_t(lzwd_pkg::out_t)) out_ch ();

  lz_window_byte_decompressor i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  lzwd_stream_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch.valid),
    .in_ready_i   (in_ch.ready),
    .in_item_i    (in_ch.payload),
    .out_valid_i  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_item_i   (out_ch.payload),
    .errors_o     (mismatches),
    .pending_o    (pending),
    .checked_o    (checked),
    .flagged_o    (flagged),
    .stream_ends_o(stream_ends),
    .stream_idle_o(stream_idle)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #7_200_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic bit quiet_window();
    return (sent_items >= QUIET_FROM) && (sent_items < QUIET_TO);
  endfunction

  function automatic logic [7:0] copy_code(input int unsigned n, input int unsigned distance);
    logic [4:0] len_field;
    logic [1:0] hi;
    len_field = 5'(n - lzwd_pkg::MIN_COPY_LEN);
    hi = 2'((distance - 1) >> 8);
    return COPY_FLAG | {1'b0, len_field, hi};
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (!quiet_window() && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= lzwd_pkg::in_t'(b);
    do @(posedge clk_i); while (!in_ch.ready);
    sent_items++;
  endtask

  task automatic send_header(input logic [31:0] len);
    for (int k = 0; k < 4; k++) send_byte(len[8*k +: 8]);
  endtask

  task automatic send_literals(input byte_q_t data);
    send_byte(8'(data.size() - 1));
    foreach (data[k]) send_byte(data[k]);
  endtask

  task automatic send_copy(input int unsigned n, input int unsigned distance);
    send_byte(copy_code(n, distance));
    send_byte(8'(distance - 1));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Random bytes from inside a stream, then long copies until the stream ends.
  task automatic scramble_stream();
    int unsigned left;
    left = $urandom_range(4, 16);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (!stream_idle) begin
      send_byte((left > 0) ? 8'($urandom) : LONG_COPY);
      if (left > 0) left--;
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_stream(input logic [31:0] len, input bit noisy,
                             input int unsigned max_tokens);
    byte_q_t     lits;
    int unsigned done_bytes;
    int unsigned tokens;
    int unsigned n;
    int unsigned distance;
    int unsigned span;
    done_bytes = 0;
    tokens = 0;
    send_header(len);
    while (done_bytes < len && tokens < max_tokens) begin
      if (noisy && $urandom_range(3) == 0) begin
        scramble_stream();
        return;
      end
      if ($urandom_range(1) == 0) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 8);
        lits.delete();
        repeat (n) lits.push_back(8'($urandom));
        send_literals(lits);
      end else begin
        n = $urandom_range(3, 34);
        span = (done_bytes > 1024) ? 1024 : done_bytes;
        if (span > 0 && $urandom_range(7) != 0) distance = $urandom_range(1, span);
        else distance = $urandom_range(1, 1024);
        send_copy(n, distance);
      end
      done_bytes += n;
      tokens++;
    end
  endtask

  initial begin
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (!held && sent_items >= HOLD_AT) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        held = 1'b1;
      end else if (!quiet_window() && $urandom_range(99) < 30) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    bit          drained;
    logic [31:0] len;
    drained = 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A zero-length header, then a copy that overshoots the length and reaches
    // before the stream start, then a copy that starts before the stream and
    // runs into real history.
    send_header(32'd0);
    send_header(32'd5);
    send_literals('{8'hFF});
    send_copy(3, 1);
    send_copy(34, 1024);
    send_header(32'd4);
    send_literals('{8'hA5, 8'h5A});
    send_copy(3, 3);

    while (sent_items < TOTAL_ITEMS) begin
      if (!drained && sent_items >= DRAIN_AT) begin
        wait_drained();
        drained = 1'b1;
      end
      case ($urandom_range(15))
        0:       len = 32'd0;
        1, 2:    len = $urandom_range(100, 400);
        default: len = $urandom_range(1, 48);
      endcase
      send_stream(len, $urandom_range(4) == 0, ANY_TOKENS);
    end
    send_stream(32'hFFFF_FFFF, 1'b0, FINAL_TOKENS);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Fed %0d compressed bytes and checked %0d decompressed bytes.",
             sent_items, checked);
    $display("%0d copied bytes lay before their stream start; %0d streams reached their length.",
             flagged, stream_ends);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/lzwd_pkg.sv
sv/lzwd_stream_if.sv
sv/lzwd_window.sv
sv/lzwd_seq.sv
sv/lz_window_byte_decompressor.sv
tb/sv/lzwd_stream_checker.sv
tb/sv/lz_window_byte_decompressor_tb.sv
